>>> src/fsc_pkg.sv
// fsc_pkg: shared types, codes and constants of the frustum sphere culler
// no dependencies
`default_nettype none

package fsc_pkg;

	localparam int NUM_VIEWS_DEF = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_PLANES    = 6;
	// slot index width carried between modules, enough for the largest view count
	localparam int SLOT_IDX_W    = 4;
	// plane test accumulator: three 64-bit products plus two shifted terms
	localparam int ACC_W         = 67;

	typedef enum logic [1:0] {
		ACT_WRITE    = 2'd0,
		ACT_TEST_ALL = 2'd1,
		ACT_TEST_ONE = 2'd2,
		ACT_NOP      = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQRT,
		ST_DIV,
		ST_STORE,
		ST_TEST,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		action_t            action;
		logic [1:0]         slot;
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] value;
		logic               last;
		logic signed [31:0] sphere_x;
		logic signed [31:0] sphere_y;
		logic signed [31:0] sphere_z;
		logic [30:0]        sphere_radius;
	} item_t;

	typedef struct packed {
		logic culled;
		logic slot_empty;
	} result_t;

	typedef struct packed {
		logic                  latch;
		logic                  stg_wr;
		logic                  ld_clr;
		logic                  ld_issue;
		logic                  sq_init;
		logic                  sq_step;
		logic                  dv_init;
		logic                  dv_step;
		logic                  dv_fin;
		logic                  pl_wr;
		logic                  t_clr;
		logic                  t_issue;
		logic                  t_end;
		logic                  res_load;
		logic                  res_empty;
		logic [1:0]            j;
		logic [2:0]            p;
		logic [SLOT_IDX_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> src/frustum_sphere_culler.sv
// frustum_sphere_culler: top level, controller plus datapath; depends on fsc_pkg, fsc_ctrl, fsc_dp
// one item at a time. a write marked last with a slot in range commits six planes, each
// in turn through load, root and four divides, then store
// sphere test: one plane a cycle, empty slots stepped over, then drain to the result;
// a single-slot test of an empty or out-of-range slot skips the planes and flags slot_empty
// asynchronous active-low reset empties all slots; staged and plane contents hold until rewritten
`default_nettype none

module frustum_sphere_culler #(
	parameter int NUM_VIEWS = fsc_pkg::NUM_VIEWS_DEF,
	parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_ready,
	input  fsc_pkg::item_t   item,
	output logic             result_valid,
	input  wire              result_ready,
	output fsc_pkg::result_t result
);

	fsc_pkg::cmd_t    cmd;
	fsc_pkg::status_t status;

	fsc_ctrl #(
		.NUM_VIEWS(NUM_VIEWS),
		.FRAC_BITS(FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.status    (status),
		.cmd       (cmd)
	);

	fsc_dp #(
		.NUM_VIEWS(NUM_VIEWS),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.culled && result.slot_empty))
		else $error("culled and slot_empty both set");

	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (item.action == fsc_pkg::ACT_TEST_ALL ||
		 item.action == fsc_pkg::ACT_TEST_ONE)) |=> !item_ready)
		else $error("new beat taken while a test runs");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!item_ready))
		else $error("result appeared without a test in flight");

endmodule

`default_nettype wire

>>> src/fsc_ctrl.sv
// fsc_ctrl: sequencer for element writes, plane commits and sphere tests
// depends on fsc_pkg
`default_nettype none

module fsc_ctrl #(
	parameter int NUM_VIEWS = fsc_pkg::NUM_VIEWS_DEF,
	parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_ready,
	input  fsc_pkg::item_t   item,
	input  fsc_pkg::status_t status,
	output fsc_pkg::cmd_t    cmd
);

	localparam int DW     = 32 + FRAC_BITS;
	localparam int CNT_W  = $clog2(DW + 2);
	localparam int SLOT_W = (NUM_VIEWS > 1) ? $clog2(NUM_VIEWS) : 1;

	fsc_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [1:0]           j_q, j_d;
	logic [2:0]           p_q, p_d;
	logic [SLOT_W-1:0]    s_q, s_d;
	logic                 one_q, one_d;
	logic                 empty_q, empty_d;
	logic [NUM_VIEWS-1:0] valid_q, valid_d;

	logic              accept;
	logic              in_range;
	logic [SLOT_W-1:0] in_idx;

	assign accept   = item_valid && item_ready;
	assign in_range = 32'(item.slot) < 32'(NUM_VIEWS);
	assign in_idx   = SLOT_W'(item.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsc_pkg::ST_IDLE;
			cnt_q   <= '0;
			j_q     <= '0;
			p_q     <= '0;
			s_q     <= '0;
			one_q   <= 1'b0;
			empty_q <= 1'b0;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			j_q     <= j_d;
			p_q     <= p_d;
			s_q     <= s_d;
			one_q   <= one_d;
			empty_q <= empty_d;
			valid_q <= valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		j_d        = j_q;
		p_d        = p_q;
		s_d        = s_q;
		one_d      = one_q;
		empty_d    = empty_q;
		valid_d    = valid_q;
		item_ready = 1'b0;
		cmd        = '0;
		cmd.j      = j_q;
		cmd.p      = p_q;
		cmd.slot   = fsc_pkg::SLOT_IDX_W'(s_q);
		cmd.res_empty = empty_q;

		case (state_q)
			fsc_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (accept) begin
					cmd.latch = 1'b1;
					case (item.action)
						fsc_pkg::ACT_WRITE: begin
							cmd.stg_wr = 1'b1;
							if (item.last && in_range) begin
								s_d     = in_idx;
								p_d     = '0;
								cnt_d   = '0;
								state_d = fsc_pkg::ST_LOAD;
							end
						end
						fsc_pkg::ACT_TEST_ALL: begin
							cmd.t_clr = 1'b1;
							s_d     = '0;
							p_d     = '0;
							one_d   = 1'b0;
							empty_d = 1'b0;
							state_d = fsc_pkg::ST_TEST;
						end
						fsc_pkg::ACT_TEST_ONE: begin
							cmd.t_clr = 1'b1;
							s_d     = in_idx;
							p_d     = '0;
							one_d   = 1'b1;
							if (in_range && valid_q[in_idx]) begin
								empty_d = 1'b0;
								state_d = fsc_pkg::ST_TEST;
							end else begin
								empty_d = 1'b1;
								state_d = fsc_pkg::ST_FIN;
							end
						end
						default: ;
					endcase
				end
			end

			fsc_pkg::ST_LOAD: begin
				// raw coefficients, halving and squares run in the datapath pipeline
				cmd.j        = cnt_q[1:0];
				cmd.ld_clr   = (cnt_q == '0);
				cmd.ld_issue = (cnt_q < CNT_W'(4));
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(7)) begin
					cmd.sq_init = 1'b1;
					cnt_d       = '0;
					state_d     = fsc_pkg::ST_SQRT;
				end
			end

			fsc_pkg::ST_SQRT: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(31)) begin
					cnt_d   = '0;
					j_d     = '0;
					state_d = fsc_pkg::ST_DIV;
				end
			end

			fsc_pkg::ST_DIV: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == '0) begin
					cmd.dv_init = 1'b1;
				end else if (cnt_q == CNT_W'(DW + 1)) begin
					cmd.dv_fin = 1'b1;
					cnt_d      = '0;
					j_d        = j_q + 1'b1;
					if (j_q == 2'd3) begin
						state_d = fsc_pkg::ST_STORE;
					end
				end else begin
					cmd.dv_step = 1'b1;
				end
			end

			fsc_pkg::ST_STORE: begin
				cmd.pl_wr = 1'b1;
				cnt_d     = '0;
				if (p_q == 3'(fsc_pkg::NUM_PLANES - 1)) begin
					valid_d[s_q] = 1'b1;
					state_d      = fsc_pkg::ST_IDLE;
				end else begin
					p_d     = p_q + 1'b1;
					state_d = fsc_pkg::ST_LOAD;
				end
			end

			fsc_pkg::ST_TEST: begin
				// one plane a cycle; slots without planes are stepped over
				if (valid_q[s_q] && p_q != 3'(fsc_pkg::NUM_PLANES - 1)) begin
					cmd.t_issue = 1'b1;
					p_d         = p_q + 1'b1;
				end else begin
					cmd.t_issue = valid_q[s_q];
					cmd.t_end   = valid_q[s_q];
					p_d         = '0;
					if (one_q || s_q == SLOT_W'(NUM_VIEWS - 1)) begin
						cnt_d   = '0;
						state_d = fsc_pkg::ST_DRAIN;
					end else begin
						s_d = s_q + 1'b1;
					end
				end
			end

			fsc_pkg::ST_DRAIN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(3)) begin
					state_d = fsc_pkg::ST_FIN;
				end
			end

			fsc_pkg::ST_FIN: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = fsc_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = fsc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/fsc_dp.sv
// fsc_dp: staging store, plane extraction with square root and divider,
// plane store, plane test pipeline and result register; depends on fsc_pkg
`default_nettype none

module fsc_dp #(
	parameter int NUM_VIEWS = fsc_pkg::NUM_VIEWS_DEF,
	parameter int FRAC_BITS = fsc_pkg::FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  fsc_pkg::item_t    item,
	input  fsc_pkg::cmd_t     cmd,
	output fsc_pkg::status_t  status,
	output logic              result_valid,
	input  wire               result_ready,
	output fsc_pkg::result_t  result
);

	localparam int DW   = 32 + FRAC_BITS;
	localparam int NPL  = NUM_VIEWS * fsc_pkg::NUM_PLANES;
	localparam int PA_W = $clog2(NPL);
	localparam int AW   = fsc_pkg::ACC_W;
	localparam logic [1:0] W_ROW = 2'd3;

	// staging store and plane store
	logic signed [31:0] stg_mem [16];
	logic [127:0]       pl_mem [NPL];

	logic signed [31:0] x_q, y_q, z_q;
	logic [30:0]        rad_q;

	always_ff @(posedge clk) begin
		if (cmd.stg_wr) begin
			stg_mem[{item.row, item.col}] <= item.value;
		end
		if (cmd.latch) begin
			x_q   <= item.sphere_x;
			y_q   <= item.sphere_y;
			z_q   <= item.sphere_z;
			rad_q <= item.sphere_radius;
		end
	end

	// plane store address: slot * 6 + plane
	logic [6:0]      addr_w;
	logic [PA_W-1:0] addr;
	assign addr_w = 7'({cmd.slot, 2'b00}) + 7'({cmd.slot, 1'b0}) + 7'(cmd.p);
	assign addr   = PA_W'(addr_w);

	// raw coefficient pipeline
	logic signed [31:0] rda_s1, rdb_s1;
	logic [1:0]         j_s1;
	logic               ldv_s1, sqv_s2, sqv_s3;
	logic signed [32:0] raw_c, hsum_c;
	logic signed [31:0] h_c, h_s2;
	logic signed [31:0] h_q [4];
	logic signed [63:0] sqp_c;
	logic [63:0]        sq_s3, sum_q;

	assign raw_c  = cmd.p[0] ? ({rda_s1[31], rda_s1} - {rdb_s1[31], rdb_s1})
	                         : ({rda_s1[31], rda_s1} + {rdb_s1[31], rdb_s1});
	// halve toward zero
	assign hsum_c = raw_c + {32'b0, raw_c[32]};
	assign h_c    = hsum_c[32:1];
	assign sqp_c  = h_s2 * h_s2;

	always_ff @(posedge clk) begin
		if (cmd.ld_issue) begin
			rda_s1 <= stg_mem[{W_ROW, cmd.j}];
			rdb_s1 <= stg_mem[{cmd.p[2:1], cmd.j}];
			j_s1   <= cmd.j;
		end
		if (ldv_s1) begin
			h_q[j_s1] <= h_c;
			h_s2      <= h_c;
		end
		sq_s3 <= sqp_c;
		if (cmd.ld_clr) begin
			sum_q <= '0;
		end else if (sqv_s3) begin
			sum_q <= sum_q + sq_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ldv_s1 <= 1'b0;
			sqv_s2 <= 1'b0;
			sqv_s3 <= 1'b0;
		end else begin
			ldv_s1 <= cmd.ld_issue;
			sqv_s2 <= ldv_s1 && (j_s1 != W_ROW);
			sqv_s3 <= sqv_s2;
		end
	end

	// bit-pair square root of the sum of squares
	logic [63:0] n_q, res_q, bit_q, rb_c;
	logic [31:0] len;
	assign rb_c = res_q + bit_q;
	assign len  = res_q[31:0];

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			n_q   <= sum_q;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (cmd.sq_step) begin
			if (n_q >= rb_c) begin
				n_q   <= n_q - rb_c;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic signed [31:0] hsel;
	logic [31:0]        mag;
	logic [DW-1:0]      num_q;
	logic [31:0]        rem_q;
	logic [32:0]        t_c;
	logic               ge_c;
	logic               ovf_pos, ovf_neg;
	logic [31:0]        coef_c;
	logic [31:0]        coef_q [4];

	assign hsel = h_q[cmd.j];
	assign mag  = hsel[31] ? (~hsel + 32'd1) : hsel;
	assign t_c  = {rem_q, num_q[DW-1]};
	assign ge_c = t_c >= {1'b0, len};

	assign ovf_pos = |num_q[DW-1:31];
	assign ovf_neg = (|num_q[DW-1:32]) || (num_q[31] && (|num_q[30:0]));

	always_comb begin
		if (len == '0) begin
			coef_c = '0;
		end else if (hsel[31]) begin
			coef_c = ovf_neg ? 32'h8000_0000 : (~num_q[31:0] + 32'd1);
		end else begin
			coef_c = ovf_pos ? 32'h7FFF_FFFF : num_q[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dv_init) begin
			num_q <= {mag, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
		end else if (cmd.dv_step) begin
			rem_q <= ge_c ? 32'(t_c - {1'b0, len}) : t_c[31:0];
			num_q <= {num_q[DW-2:0], ge_c};
		end
		if (cmd.dv_fin) begin
			coef_q[cmd.j] <= coef_c;
		end
		if (cmd.pl_wr) begin
			pl_mem[addr] <= {coef_q[3], coef_q[2], coef_q[1], coef_q[0]};
		end
	end

	// plane test pipeline
	logic [127:0]          pl_s1;
	logic signed [31:0]    n0_c, n1_c, n2_c, n3_c;
	logic signed [63:0]    m0_s2, m1_s2, m2_s2;
	logic signed [AW-1:0]  dt_s2, rt_s2;
	logic signed [AW-1:0]  a_s3, b_s3, tot_c;
	logic                  tv_s1, tv_s2, tv_s3, tv_s4;
	logic                  te_s1, te_s2, te_s3, te_s4;
	logic                  flag_s4, hit_q, vis_q;

	assign n0_c  = pl_s1[31:0];
	assign n1_c  = pl_s1[63:32];
	assign n2_c  = pl_s1[95:64];
	assign n3_c  = pl_s1[127:96];
	assign tot_c = a_s3 + b_s3;

	always_ff @(posedge clk) begin
		if (cmd.t_issue) begin
			pl_s1 <= pl_mem[addr];
		end
		m0_s2 <= n0_c * x_q;
		m1_s2 <= n1_c * y_q;
		m2_s2 <= n2_c * z_q;
		dt_s2 <= {{(AW-32){n3_c[31]}}, n3_c} <<< FRAC_BITS;
		rt_s2 <= {{(AW-31){1'b0}}, rad_q} << FRAC_BITS;
		a_s3  <= {{(AW-64){m0_s2[63]}}, m0_s2} + {{(AW-64){m1_s2[63]}}, m1_s2};
		b_s3  <= {{(AW-64){m2_s2[63]}}, m2_s2} + dt_s2 + rt_s2;
		// centre below minus the radius
		flag_s4 <= tot_c[AW-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			tv_s2 <= 1'b0;
			tv_s3 <= 1'b0;
			tv_s4 <= 1'b0;
			te_s1 <= 1'b0;
			te_s2 <= 1'b0;
			te_s3 <= 1'b0;
			te_s4 <= 1'b0;
			hit_q <= 1'b0;
			vis_q <= 1'b0;
		end else begin
			tv_s1 <= cmd.t_issue;
			te_s1 <= cmd.t_end;
			tv_s2 <= tv_s1;
			te_s2 <= te_s1;
			tv_s3 <= tv_s2;
			te_s3 <= te_s2;
			tv_s4 <= tv_s3;
			te_s4 <= te_s3;
			if (cmd.t_clr) begin
				hit_q <= 1'b0;
				vis_q <= 1'b0;
			end else if (tv_s4) begin
				if (te_s4) begin
					// a slot that no plane culls keeps the sphere visible
					if (!(hit_q || flag_s4)) begin
						vis_q <= 1'b1;
					end
					hit_q <= 1'b0;
				end else begin
					hit_q <= hit_q || flag_s4;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.res_load) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			result.culled     <= !cmd.res_empty && !vis_q;
			result.slot_empty <= cmd.res_empty;
		end
	end

	assign status.out_free = !result_valid || result_ready;

endmodule

`default_nettype wire

>>> tb/sv/tb_frustum_sphere_culler.sv
// tb_frustum_sphere_culler: drives matrix loads and sphere tests into the culler
// and checks every result beat against a plane-extraction predictor; depends on fsc_pkg and frustum_sphere_culler
`default_nettype none

module tb_frustum_sphere_culler;

	localparam int FB = fsc_pkg::FRAC_BITS_DEF;
	localparam int NV = fsc_pkg::NUM_VIEWS_DEF;
	localparam int NP = fsc_pkg::NUM_PLANES;

	class cull_scoreboard;
		logic signed [31:0] staged [16];
		logic signed [31:0] planes [NV][NP][4];
		bit                 live [NV];
		fsc_pkg::result_t   pending [$];
		int                 errors;

		function new();
			errors = 0;
			foreach (live[s]) live[s] = 0;
		endfunction

		function void report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endfunction

		function longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= res + bitv) begin
					n -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function logic signed [31:0] scale_coef(longint h, longint unsigned len);
			longint unsigned mag, q;
			mag = (h < 0) ? longint'(-h) : h;
			q = (mag << FB) / len;
			if (h < 0) begin
				if (q > 64'h80000000) q = 64'h80000000;
				return 32'(-longint'(q));
			end
			if (q > 64'h7fffffff) q = 64'h7fffffff;
			return 32'(q);
		endfunction

		function void commit(int s);
			longint h [4];
			longint a, b, r;
			longint unsigned sum, len;
			for (int p = 0; p < NP; p++) begin
				sum = 0;
				for (int j = 0; j < 4; j++) begin
					a = staged[12 + j];
					b = staged[(p >> 1) * 4 + j];
					r = (p & 1) ? a - b : a + b;
					h[j] = r / 2;
				end
				for (int j = 0; j < 3; j++) sum += h[j] * h[j];
				len = int_sqrt(sum);
				for (int j = 0; j < 4; j++)
					planes[s][p][j] = (len == 0) ? 32'sd0 : scale_coef(h[j], len);
			end
			live[s] = 1;
		endfunction

		function bit slot_culls(int s, fsc_pkg::item_t it);
			logic signed [71:0] n0, n1, n2, n3, cx, cy, cz, acc, thr;
			for (int p = 0; p < NP; p++) begin
				n0 = planes[s][p][0];
				n1 = planes[s][p][1];
				n2 = planes[s][p][2];
				n3 = planes[s][p][3];
				cx = it.sphere_x;
				cy = it.sphere_y;
				cz = it.sphere_z;
				acc = n0 * cx + n1 * cy + n2 * cz + (n3 <<< FB);
				thr = $signed({41'd0, it.sphere_radius});
				thr = -(thr <<< FB);
				if (acc < thr) return 1;
			end
			return 0;
		endfunction

		function void note(fsc_pkg::item_t it);
			fsc_pkg::result_t r;
			case (it.action)
				fsc_pkg::ACT_WRITE: begin
					staged[{it.row, it.col}] = it.value;
					if (it.last && it.slot < NV) commit(int'(it.slot));
				end
				fsc_pkg::ACT_TEST_ALL: begin
					r.culled = 1'b1;
					r.slot_empty = 1'b0;
					for (int s = 0; s < NV; s++)
						if (live[s] && !slot_culls(s, it)) r.culled = 1'b0;
					pending.push_back(r);
				end
				fsc_pkg::ACT_TEST_ONE: begin
					if (it.slot >= NV || !live[it.slot]) begin
						r.culled = 1'b0;
						r.slot_empty = 1'b1;
					end else begin
						r.culled = slot_culls(int'(it.slot), it);
						r.slot_empty = 1'b0;
					end
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check(fsc_pkg::result_t got);
			fsc_pkg::result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result beat %b", got));
				return;
			end
			want = pending.pop_front();
			if (got.culled !== want.culled)
				report($sformatf("culled got %b want %b", got.culled, want.culled));
			if (got.slot_empty !== want.slot_empty)
				report($sformatf("slot_empty got %b want %b", got.slot_empty, want.slot_empty));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	fsc_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	fsc_pkg::result_t result;

	cull_scoreboard sb;
	int      sent;
	int      cyc;
	bit      staged_full;

	frustum_sphere_culler dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) cyc <= cyc + 1;

	task automatic drive_item(fsc_pkg::item_t it);
		bit quiet;
		quiet = (sent >= 250 && sent < 330);
		while (!quiet && $urandom_range(99) < 14) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note(it);
		sent++;
	endtask

	function automatic fsc_pkg::item_t blank_item(fsc_pkg::action_t act);
		fsc_pkg::item_t it;
		it = '0;
		it.action = act;
		return it;
	endfunction

	function automatic fsc_pkg::item_t sphere_item(fsc_pkg::action_t act, logic [1:0] s);
		fsc_pkg::item_t it;
		it = blank_item(act);
		it.slot = s;
		if ($urandom_range(9) < 8) begin
			it.sphere_x = $signed($urandom_range(524288)) - 262144;
			it.sphere_y = $signed($urandom_range(524288)) - 262144;
			it.sphere_z = $signed($urandom_range(524288)) - 262144;
		end else begin
			it.sphere_x = $urandom;
			it.sphere_y = $urandom;
			it.sphere_z = $urandom;
		end
		case ($urandom_range(5))
			0: it.sphere_radius = 31'd0;
			1: it.sphere_radius = 31'h7fffffff;
			2: it.sphere_radius = 31'($urandom);
			default: it.sphere_radius = 31'($urandom_range(131072));
		endcase
		it.row = 2'($urandom);
		it.col = 2'($urandom);
		it.value = $urandom;
		it.last = 1'($urandom);
		return it;
	endfunction

	function automatic logic signed [31:0] element(int kind, int r, int c);
		case (kind)
			0: return (r == c ? 32'sd65536 : 32'sd0) + $signed($urandom_range(8192)) - 4096;
			1: return $signed($urandom_range(262144)) - 131072;
			2: return $urandom;
			// normals cancel on the minus planes, zero-length case
			3: return (r == 3 && c == 3) ? 32'sd65536 : (c < 3 ? 32'sd131072 : 32'sd0);
			default: begin
				case ($urandom_range(3))
					0: return 32'sh80000000;
					1: return 32'sh7fffffff;
					2: return 32'sd0;
					default: return 32'sd1;
				endcase
			end
		endcase
	endfunction

	task automatic load_matrix(int kind, logic [1:0] s);
		fsc_pkg::item_t it;
		for (int k = 0; k < 16; k++) begin
			it = blank_item(fsc_pkg::ACT_WRITE);
			it.row = 2'(k / 4);
			it.col = 2'(k % 4);
			it.slot = s;
			it.value = element(kind, k / 4, k % 4);
			it.last = (k == 15);
			drive_item(it);
		end
		staged_full = 1;
	endtask

	// receiver: random back-pressure, one long hold-off and one quiet stretch
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready) sb.check(result);
			if (cyc >= 6000 && cyc < 8000)
				result_ready <= 1'b0;
			else if (cyc >= 12000 && cyc < 16000)
				result_ready <= 1'b1;
			else
				result_ready <= ($urandom_range(99) >= 14);
		end
	end

	initial begin
		#4000000;
		$display("frustum_sphere_culler test failed");
		$finish;
	end

	initial begin
		fsc_pkg::item_t it;
		int             pick;
		sb = new();
		sent = 0;
		cyc = 0;
		staged_full = 0;
		item_valid = 1'b0;
		item = '0;
		arst_n = 1'b0;
		#1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no slot valid yet: all-slot test culls, single-slot test flags empty
		drive_item(sphere_item(fsc_pkg::ACT_TEST_ALL, 2'd0));
		drive_item(sphere_item(fsc_pkg::ACT_TEST_ONE, 2'd0));
		drive_item(sphere_item(fsc_pkg::ACT_NOP, 2'd1));
		load_matrix(0, 2'd3);
		it = sphere_item(fsc_pkg::ACT_TEST_ONE, 2'd3);
		it.sphere_x = 0; it.sphere_y = 0; it.sphere_z = 0; it.sphere_radius = 0;
		drive_item(it);
		it.sphere_x = 32'sh80000000;
		drive_item(it);
		it = sphere_item(fsc_pkg::ACT_TEST_ALL, 2'd0);
		it.sphere_x = 32'sh7fffffff; it.sphere_radius = 31'h7fffffff;
		drive_item(it);
		drive_item(sphere_item(fsc_pkg::ACT_TEST_ONE, 2'd2));

		while (sent < 520) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				load_matrix(int'($urandom_range(4)), 2'($urandom));
			end else if (pick < 14) begin
				if ($urandom_range(1)) begin
					drive_item(sphere_item(fsc_pkg::ACT_NOP, 2'($urandom)));
				end else begin
					// stray write, sometimes a commit of a partly updated matrix
					it = blank_item(fsc_pkg::ACT_WRITE);
					it.row = 2'($urandom);
					it.col = 2'($urandom);
					it.slot = 2'($urandom);
					it.value = $urandom;
					it.last = staged_full && ($urandom_range(3) == 0);
					it.sphere_x = $urandom;
					drive_item(it);
				end
			end else if (pick < 55) begin
				drive_item(sphere_item(fsc_pkg::ACT_TEST_ALL, 2'($urandom)));
			end else begin
				drive_item(sphere_item(fsc_pkg::ACT_TEST_ONE, 2'($urandom)));
			end
		end
		item_valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (1600) @(posedge clk);
		if (sb.errors == 0)
			$display("frustum_sphere_culler test passed");
		else
			$display("frustum_sphere_culler test failed");
		$finish;
	end
endmodule

`default_nettype wire

>>> files.f
src/fsc_pkg.sv
src/fsc_ctrl.sv
src/fsc_dp.sv
src/frustum_sphere_culler.sv
tb/sv/tb_frustum_sphere_culler.sv
